### rtl/dfm_pkg.sv
// ----------------------------------------------------------------------------
// dfm_pkg
// Shared types, codes and helpers for the destination filtered mailbox.
// ----------------------------------------------------------------------------
package dfm_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned PayloadBytes  = 8;

  localparam int unsigned IdW    = 8;
  localparam int unsigned KindW  = 16;
  localparam int unsigned BodyW  = 56;
  localparam int unsigned PendW  = 5;
  localparam int unsigned OpW    = 2;

  localparam logic [PendW-1:0] PendMax = '1;

  typedef enum logic [OpW-1:0] {
    OP_SEND  = 2'd0,
    OP_RECV  = 2'd1,
    OP_COUNT = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [IdW-1:0]   sender;
    logic [IdW-1:0]   dest;
    logic [KindW-1:0] kind;
    logic [BodyW-1:0] body;
  } entry_t;

  typedef struct packed {
    logic             ok;
    entry_t           msg;
    logic [PendW-1:0] pending;
  } result_t;

  // Keeps the bytes ahead of the first zero byte, at most PayloadBytes-1 of them.
  function automatic logic [BodyW-1:0] clip_body(input logic [BodyW-1:0] raw);
    logic [BodyW-1:0] kept;
    logic             alive;
    kept  = '0;
    alive = 1'b1;
    for (int pos = 0; pos < BodyW / 8; pos++) begin
      if (pos >= PayloadBytes - 1 || raw[pos*8 +: 8] == 8'h00) begin
        alive = 1'b0;
      end
      if (alive) begin
        kept[pos*8 +: 8] = raw[pos*8 +: 8];
      end
    end
    return kept;
  endfunction

endpackage

### rtl/dfm_store.sv
// ----------------------------------------------------------------------------
// dfm_store
// Message store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dfm_store
  import dfm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  entry_t          wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output entry_t          rdata_o
);

  entry_t mem [QUEUE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/dfm_ctrl.sv
// ----------------------------------------------------------------------------
// dfm_ctrl
// Sequencer that walks the store one entry at a time with a single
// destination comparator, and moves later entries down after a receive.
// ----------------------------------------------------------------------------
module dfm_ctrl
  import dfm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [OpW-1:0]   opcode_i,
  input  logic [IdW-1:0]   sender_id_i,
  input  logic [IdW-1:0]   dest_id_i,
  input  logic [KindW-1:0] msg_kind_i,
  input  logic [BodyW-1:0] msg_body_i,
  input  logic             done_ack_i,
  output logic             idle_o,
  output logic             done_o,
  output result_t          result_o,
  output logic             mem_we_o,
  output logic [IdxW-1:0]  mem_waddr_o,
  output entry_t           mem_wdata_o,
  output logic [IdxW-1:0]  mem_raddr_o,
  input  entry_t           mem_rdata_i
);

  localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);
  localparam logic [CntW-1:0] OneC   = CntW'(1);

  state_e           state_q, state_d;
  logic [OpW-1:0]   op_q, op_d;
  logic [IdW-1:0]   dst_q, dst_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  fill_q, fill_d;
  result_t          res_q, res_d;
  logic             dest_match;
  logic             at_end;
  logic [CntW-1:0]  idx_prev;
  entry_t           send_entry;

  // The one comparator shared by receive and count.
  assign dest_match = (mem_rdata_i.dest == dst_q);
  assign at_end     = (idx_q == fill_q);
  assign idx_prev   = idx_q - OneC;

  assign send_entry.sender = sender_id_i;
  assign send_entry.dest   = dest_id_i;
  assign send_entry.kind   = msg_kind_i;
  assign send_entry.body   = clip_body(msg_body_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (opcode_i == OP_RECV || opcode_i == OP_COUNT) begin
            state_d = ST_SCAN_RD;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN_RD: begin
        state_d = at_end ? ST_DONE : ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (op_q == OP_RECV && dest_match) begin
          state_d = ST_SHIFT_RD;
        end else begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_SHIFT_RD: begin
        state_d = at_end ? ST_DONE : ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        state_d = ST_SHIFT_RD;
      end
      ST_DONE: begin
        if (done_ack_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    op_d        = op_q;
    dst_d       = dst_q;
    idx_d       = idx_q;
    fill_d      = fill_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = fill_q[IdxW-1:0];
    mem_wdata_o = send_entry;
    mem_raddr_o = idx_q[IdxW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d  = opcode_i;
          dst_d = dest_id_i;
          idx_d = '0;
          res_d = '0;
          if (opcode_i == OP_SEND && fill_q < DepthC) begin
            mem_we_o   = 1'b1;
            fill_d     = fill_q + OneC;
            res_d.ok   = 1'b1;
          end
        end
      end
      ST_SCAN_CMP: begin
        idx_d = idx_q + OneC;
        if (dest_match) begin
          if (op_q == OP_RECV) begin
            res_d.ok  = 1'b1;
            res_d.msg = mem_rdata_i;
          end else if (res_q.pending != PendMax) begin
            res_d.pending = res_q.pending + PendW'(1);
          end
        end
      end
      ST_SHIFT_RD: begin
        if (at_end) begin
          fill_d = fill_q - OneC;
        end
      end
      ST_SHIFT_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_prev[IdxW-1:0];
        mem_wdata_o = mem_rdata_i;
        idx_d       = idx_q + OneC;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    dst_q <= dst_d;
    idx_q <= idx_d;
    res_q <= res_d;
  end

  assign idle_o   = (state_q == ST_IDLE);
  assign done_o   = (state_q == ST_DONE);
  assign result_o = res_q;

endmodule

### rtl/destination_filtered_mailbox.sv
// ----------------------------------------------------------------------------
// destination_filtered_mailbox
// Shared message mailbox kept in arrival order with send, receive and count.
// ----------------------------------------------------------------------------
// One word is taken at a time. A send goes from idle straight to done. A
// receive or a count walks the stored messages one entry at a time, with a
// scan read state and a scan compare state per entry, through a single read
// port and one destination comparator; a receive then moves each later entry
// down one place, with a shift read state and a shift write state per entry.
// The result word waits in an output register, so a new word is taken while
// the previous result is still stalled; a finished operation waits only while
// that register is full and stalled. After reset the mailbox is empty at once.
module destination_filtered_mailbox
  import dfm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [OpW-1:0]   opcode_i,
  input  logic [IdW-1:0]   sender_id_i,
  input  logic [IdW-1:0]   dest_id_i,
  input  logic [KindW-1:0] msg_kind_i,
  input  logic [BodyW-1:0] msg_body_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             ok_o,
  output logic [IdW-1:0]   got_sender_o,
  output logic [IdW-1:0]   got_dest_o,
  output logic [KindW-1:0] got_kind_o,
  output logic [BodyW-1:0] got_body_o,
  output logic [PendW-1:0] pending_o
);

  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic            idle;
  logic            done;
  logic            done_ack;
  logic            start;
  result_t         result;
  result_t         out_q;
  logic            out_valid_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  entry_t          mem_wdata;
  logic [IdxW-1:0] mem_raddr;
  entry_t          mem_rdata;

  assign in_stall_o = !idle;
  assign start      = in_valid_i && idle;
  assign done_ack   = done && (!out_valid_q || !out_stall_i);

  dfm_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .opcode_i    (opcode_i),
    .sender_id_i (sender_id_i),
    .dest_id_i   (dest_id_i),
    .msg_kind_i  (msg_kind_i),
    .msg_body_i  (msg_body_i),
    .done_ack_i  (done_ack),
    .idle_o      (idle),
    .done_o      (done),
    .result_o    (result),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  dfm_store #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done_ack) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_ack) begin
      out_q <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = out_q.ok;
  assign got_sender_o = out_q.msg.sender;
  assign got_dest_o   = out_q.msg.dest;
  assign got_kind_o   = out_q.msg.kind;
  assign got_body_o   = out_q.msg.body;
  assign pending_o    = out_q.pending;

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the destination filtered mailbox. A directed table
// covers the empty, full, no-match and unused-opcode cases. Random sends,
// receives and counts follow. Every result word is compared against a
// behavioral mailbox in the bench, or for typed rows against the table's ok
// and pending, with random gaps on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import dfm_pkg::*;

  localparam logic [OpW-1:0] OP_UNUSED  = 2'd3;
  localparam int unsigned    MboxDepth  = QueueDepthDef;
  localparam int             RandWords  = 800;
  localparam int             CycleLimit = 1000000;

  typedef struct {
    logic [OpW-1:0]   op;
    logic [IdW-1:0]   sender;
    logic [IdW-1:0]   dest;
    logic [KindW-1:0] kind;
    logic [BodyW-1:0] body;
    int               reps;
    bit               typed;
    logic             want_ok;
    logic [PendW-1:0] want_pend;
  } stim_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             out_stall_i = 1'b0;
  logic [OpW-1:0]   opcode_i    = '0;
  logic [IdW-1:0]   sender_id_i = '0;
  logic [IdW-1:0]   dest_id_i   = '0;
  logic [KindW-1:0] msg_kind_i  = '0;
  logic [BodyW-1:0] msg_body_i  = '0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic             ok_o;
  logic [IdW-1:0]   got_sender_o;
  logic [IdW-1:0]   got_dest_o;
  logic [KindW-1:0] got_kind_o;
  logic [BodyW-1:0] got_body_o;
  logic [PendW-1:0] pending_o;

  entry_t      held_msgs [MboxDepth];
  int unsigned held_count = 0;
  result_t     replies_due [$];
  int          fault_count = 0;
  int          replies_seen = 0;
  int          cycle_count = 0;

  destination_filtered_mailbox u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .sender_id_i  (sender_id_i),
    .dest_id_i    (dest_id_i),
    .msg_kind_i   (msg_kind_i),
    .msg_body_i   (msg_body_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ok_o         (ok_o),
    .got_sender_o (got_sender_o),
    .got_dest_o   (got_dest_o),
    .got_kind_o   (got_kind_o),
    .got_body_o   (got_body_o),
    .pending_o    (pending_o)
  );

  always #5 clk_i = ~clk_i;

  // Text ends at the first zero byte, and only PayloadBytes-1 bytes are kept.
  function automatic logic [BodyW-1:0] trim_text(input logic [BodyW-1:0] raw);
    logic [BodyW-1:0] kept;
    kept = '0;
    for (int b = 0; b < PayloadBytes - 1 && b < BodyW / 8; b++) begin
      if (raw[b*8 +: 8] == 8'h00) break;
      kept[b*8 +: 8] = raw[b*8 +: 8];
    end
    return kept;
  endfunction

  function automatic result_t mailbox_reply(input logic [OpW-1:0] op,
                                            input logic [IdW-1:0] sender,
                                            input logic [IdW-1:0] dest,
                                            input logic [KindW-1:0] kind,
                                            input logic [BodyW-1:0] body);
    result_t     r;
    int          hit;
    int unsigned n;
    r   = '0;
    hit = -1;
    n   = 0;
    case (op)
      OP_SEND: begin
        if (held_count < MboxDepth) begin
          held_msgs[held_count].sender = sender;
          held_msgs[held_count].dest   = dest;
          held_msgs[held_count].kind   = kind;
          held_msgs[held_count].body   = trim_text(body);
          held_count++;
          r.ok = 1'b1;
        end
      end
      OP_RECV: begin
        for (int i = 0; i < held_count; i++) begin
          if (hit < 0 && held_msgs[i].dest == dest) hit = i;
        end
        if (hit >= 0) begin
          r.ok  = 1'b1;
          r.msg = held_msgs[hit];
          // Later messages move down one place to close the gap.
          for (int j = hit + 1; j < held_count; j++) held_msgs[j-1] = held_msgs[j];
          held_count--;
        end
      end
      OP_COUNT: begin
        for (int i = 0; i < held_count; i++) begin
          if (held_msgs[i].dest == dest) n++;
        end
        r.pending = (n > PendMax) ? PendMax : n[PendW-1:0];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(15);
    if (r < 8) return 0;
    if (r < 14) return $urandom_range(3, 1);
    if (r < 15) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic post_word(input logic [OpW-1:0] op, input logic [IdW-1:0] sender,
                           input logic [IdW-1:0] dest, input logic [KindW-1:0] kind,
                           input logic [BodyW-1:0] body, input bit typed,
                           input result_t typed_reply);
    result_t reply;
    opcode_i    <= op;
    sender_id_i <= sender;
    dest_id_i   <= dest;
    msg_kind_i  <= kind;
    msg_body_i  <= body;
    in_valid_i  <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    reply = mailbox_reply(op, sender, dest, kind, body);
    if (typed) reply = typed_reply;
    replies_due.push_back(reply);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (replies_due.size() == 0) begin
        $error("result word with no expectation waiting");
        fault_count++;
      end else begin
        want = replies_due.pop_front();
        check_field("ok", 64'(want.ok), 64'(ok_o));
        check_field("got_sender", 64'(want.msg.sender), 64'(got_sender_o));
        check_field("got_dest", 64'(want.msg.dest), 64'(got_dest_o));
        check_field("got_kind", 64'(want.msg.kind), 64'(got_kind_o));
        check_field("got_body", 64'(want.msg.body), 64'(got_body_o));
        check_field("pending", 64'(want.pending), 64'(pending_o));
      end
      replies_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off so the mailbox backs up.
  initial begin
    bit pressure_done;
    int r;
    pressure_done = 1'b0;
    @(posedge clk_i);
    forever begin
      if (!pressure_done && replies_seen >= 300) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        pressure_done = 1'b1;
      end
      r = $urandom_range(15);
      out_stall_i <= 1'b0;
      if (r == 0) repeat ($urandom_range(200, 100)) @(posedge clk_i);
      else repeat ($urandom_range(8, 1)) @(posedge clk_i);
      r = $urandom_range(15);
      out_stall_i <= 1'b1;
      if (r == 0) repeat ($urandom_range(60, 20)) @(posedge clk_i);
      else repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
  end

  initial begin
    stim_row_t        directed_rows [$];
    stim_row_t        row;
    result_t          typed_reply;
    logic [IdW-1:0]   dest_pool [4];
    logic [OpW-1:0]   op;
    logic [IdW-1:0]   dest;
    logic [BodyW-1:0] body;
    int               gap;
    int               r;
    bit               filling;

    //                 op        sender  dest   kind      body              reps typed ok pend
    directed_rows.push_back('{OP_COUNT,  8'h00, 8'h00, 16'h0000, 56'h0,             1, 1, 0, 0});
    directed_rows.push_back('{OP_RECV,   8'h00, 8'h00, 16'h0000, 56'h0,             1, 1, 0, 0});
    directed_rows.push_back('{OP_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, '1,                1, 1, 0, 0});
    directed_rows.push_back('{OP_SEND,   8'hFF, 8'hFF, 16'hFFFF, '1,                1, 1, 1, 0});
    directed_rows.push_back('{OP_SEND,   8'h00, 8'h00, 16'h0000, 56'h0,             1, 1, 1, 0});
    // Zero byte in the middle ends the text; the bytes above it are dropped.
    directed_rows.push_back('{OP_SEND,   8'h3C, 8'h7E, 16'h1234, 56'h77665500443322, 1, 1, 1, 0});
    directed_rows.push_back('{OP_COUNT,  8'h00, 8'hFF, 16'h0000, 56'h0,             1, 0, 0, 0});
    directed_rows.push_back('{OP_RECV,   8'h00, 8'hFF, 16'h0000, 56'h0,             1, 0, 0, 0});
    directed_rows.push_back('{OP_RECV,   8'h00, 8'h00, 16'h0000, 56'h0,             1, 0, 0, 0});
    directed_rows.push_back('{OP_SEND,   8'h10, 8'hA5, 16'h8001, 56'h01020304050607, 15, 0, 0, 0});
    // The store is full now, so this send is refused.
    directed_rows.push_back('{OP_SEND,   8'h99, 8'hA5, 16'h0BAD, 56'h0000000000AA55, 1, 1, 0, 0});
    directed_rows.push_back('{OP_COUNT,  8'h00, 8'hA5, 16'h0000, 56'h0,             1, 0, 0, 0});
    directed_rows.push_back('{OP_RECV,   8'h00, 8'h42, 16'h0000, 56'h0,             1, 1, 0, 0});
    directed_rows.push_back('{OP_RECV,   8'h00, 8'hA5, 16'h0000, 56'h0,             1, 0, 0, 0});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      typed_reply         = '0;
      typed_reply.ok      = row.want_ok;
      typed_reply.pending = row.want_pend;
      for (int rep = 0; rep < row.reps; rep++) begin
        gap = pick_gap();
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        post_word(row.op, row.sender + rep[7:0], row.dest, row.kind + rep[15:0], row.body,
                  row.typed, typed_reply);
      end
    end

    // A few hot destinations keep receives hitting; the rest spread over all ids.
    foreach (dest_pool[i]) dest_pool[i] = 8'($urandom_range(255));
    typed_reply = '0;
    filling = 1'b0;
    for (int n = 0; n < RandWords; n++) begin
      if (n % 60 == 0) filling = !filling;
      r = $urandom_range(99);
      if (filling) op = (r < 60) ? OP_SEND : (r < 80) ? OP_RECV : (r < 95) ? OP_COUNT : OP_UNUSED;
      else         op = (r < 25) ? OP_SEND : (r < 75) ? OP_RECV : (r < 93) ? OP_COUNT : OP_UNUSED;
      dest = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : dest_pool[$urandom_range(3)];
      if ($urandom_range(3) == 0) begin
        body = BodyW'({$urandom, $urandom});
      end else begin
        for (int b = 0; b < BodyW / 8; b++) begin
          body[b*8 +: 8] = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(255, 1));
        end
      end
      gap = (n >= 400 && n < 500) ? 0 : pick_gap();
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      post_word(op, 8'($urandom_range(255)), dest, 16'($urandom_range(65535)), body, 1'b0,
                typed_reply);
    end
    in_valid_i <= 1'b0;

    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
